FILE: rtl/core/slap_pkg.sv
// Package for the slot allocator with property table.
// Holds field widths, action and status codes and default sizes.
// No dependencies.
package slap_pkg;

  localparam int ENTITIES_DEF   = 1024;
  localparam int PROPERTIES_DEF = 16;

  localparam int ACTION_W = 3;
  localparam int ID_W     = 16;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 10;
  localparam int LIVE_W   = 11;

  localparam int IN_W  = 72;  // 67 bits of fields, padded to bytes
  localparam int OUT_W = 88;  // 87 bits of fields, padded to bytes

  localparam logic [ACTION_W-1:0] ACT_ALLOC = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_GET   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SET   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FRAME = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_CSUM  = 3'd6;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSLOT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  function automatic logic [VAL_W-1:0] rotl1(input logic [VAL_W-1:0] v);
    rotl1 = {v[VAL_W-2:0], v[VAL_W-1]};
  endfunction

endpackage

FILE: rtl/core/slot_allocator_property_table.sv
// Slot allocator with per-slot property table, top level.
// Depends on slap_pkg and slap_ram.
//
// Usage notes:
//  - Input stream s_*: one word per action (allocate, free, get, set,
//    set frame, clear, checksum). Output stream m_*: exactly one result
//    word per action, in order.
//  - One action at a time. Allocate of a slot and set of a slot that is
//    not valid also zero its row; clear sweeps every slot; checksum visits
//    every slot and reads each property of a valid slot through the single
//    read port of the property memory. s_tready returns as m_tvalid rises.
//  - State lives in three memories: valid bits, free stack, property rows.
//    Rows are zeroed when a slot is allocated or set while not valid, one property per cycle.
//  - After reset a clearing pass over every slot zeroes the valid bits;
//    s_tready stays low until it ends. Clear runs the same pass.
//  - A finished result waits in the output register; a new word can be
//    accepted meanwhile, but its result is held until m_tready takes the
//    pending one.
module slot_allocator_property_table #(
  parameter int ENTITIES   = slap_pkg::ENTITIES_DEF,
  parameter int PROPERTIES = slap_pkg::PROPERTIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // action[2:0], slot_id[18:3], prop_index[34:19], write_value[66:35]
  input  logic [slap_pkg::IN_W-1:0] s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // status[1:0], slot_out[11:2], read_value[43:12], checksum[75:44],
  // live_count[86:76]
  output logic [slap_pkg::OUT_W-1:0] m_tdata
);
  import slap_pkg::*;

  localparam int SW     = $clog2(ENTITIES);
  localparam int CW     = $clog2(ENTITIES + 1);
  localparam int PW     = (PROPERTIES > 1) ? $clog2(PROPERTIES) : 1;
  localparam int AW     = SW + PW;
  localparam int PDEPTH = ENTITIES * (2 ** PW);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_EXEC = 4'd2;
  localparam logic [3:0] S_AVAL = 4'd3;
  localparam logic [3:0] S_ZERO = 4'd4;
  localparam logic [3:0] S_SETW = 4'd5;
  localparam logic [3:0] S_CKV  = 4'd6;
  localparam logic [3:0] S_CKP  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  localparam logic [SW-1:0] LAST_SLOT = SW'(ENTITIES - 1);
  localparam logic [PW-1:0] LAST_PROP = PW'(PROPERTIES - 1);

  // input word fields
  logic [ACTION_W-1:0] in_action;
  logic [ID_W-1:0]     in_slot, in_prop;
  logic [VAL_W-1:0]    in_wval;
  assign in_action = s_tdata[2:0];
  assign in_slot   = s_tdata[18:3];
  assign in_prop   = s_tdata[34:19];
  assign in_wval   = s_tdata[66:35];

  logic [3:0]          state;
  logic [ACTION_W-1:0] act;
  logic [ID_W-1:0]     slot_r, prop_r;
  logic [VAL_W-1:0]    wval;
  logic [SW-1:0]       tgt;        // row being zeroed / written
  logic [SW-1:0]       ctr;        // clear sweep and checksum slot
  logic [PW-1:0]       pc;         // property counter
  logic                set_after;  // write the set value after zeroing
  logic                clr_resp;   // clear sweep owes a result
  logic [CW-1:0]       stack_depth, fresh_next, valid_count;
  logic [VAL_W-1:0]    frame, csum;
  logic [STATUS_W-1:0] res_status;
  logic [SW-1:0]       res_slot;
  logic [VAL_W-1:0]    res_rd, res_sum;

  logic slot_ok, prop_ok;
  assign slot_ok = {1'b0, slot_r} < 17'(ENTITIES);
  assign prop_ok = {1'b0, prop_r} < 17'(PROPERTIES);

  // memory ports
  logic          v_we, v_wdata, v_rdata;
  logic [SW-1:0] v_waddr, v_raddr;
  logic          k_we;
  logic [SW-1:0] k_waddr, k_wdata, k_raddr, k_rdata;
  logic          p_we;
  logic [AW-1:0] p_waddr, p_raddr;
  logic [VAL_W-1:0] p_wdata, p_rdata;

  slap_ram #(.WIDTH(1), .DEPTH(ENTITIES), .AW(SW)) u_valid (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata));

  slap_ram #(.WIDTH(SW), .DEPTH(ENTITIES), .AW(SW)) u_stack (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(k_raddr), .rdata(k_rdata));

  slap_ram #(.WIDTH(VAL_W), .DEPTH(PDEPTH), .AW(AW)) u_props (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata));

  // allocate picks the top of the free stack, else the next fresh slot
  logic          have_stack, have_fresh;
  logic [SW-1:0] alloc_slot;
  assign have_stack = stack_depth != '0;
  assign have_fresh = fresh_next < CW'(ENTITIES);
  assign alloc_slot = have_stack ? k_rdata : fresh_next[SW-1:0];

  // checksum step on the returned property
  logic [VAL_W-1:0] ck_rot, ck_row;
  assign ck_rot = rotl1(csum ^ p_rdata);
  assign ck_row = ck_rot ^ VAL_W'(ctr);

  assign s_tready = (state == S_IDLE);

  always_comb begin
    v_we    = 1'b0;
    v_waddr = slot_r[SW-1:0];
    v_wdata = 1'b0;
    v_raddr = ctr + SW'(1);
    k_we    = 1'b0;
    k_waddr = stack_depth[SW-1:0];
    k_wdata = slot_r[SW-1:0];
    k_raddr = SW'(stack_depth - CW'(1));
    p_we    = 1'b0;
    p_waddr = {slot_r[SW-1:0], prop_r[PW-1:0]};
    p_wdata = wval;
    p_raddr = {ctr, pc + PW'(1)};
    unique case (state)
      S_CLR: begin
        v_we    = 1'b1;
        v_waddr = ctr;
      end
      S_IDLE: begin
        v_raddr = in_slot[SW-1:0];
        p_raddr = {in_slot[SW-1:0], in_prop[PW-1:0]};
      end
      S_EXEC: begin
        case (act)
          ACT_ALLOC: v_raddr = alloc_slot;
          ACT_CSUM:  v_raddr = '0;
          ACT_FREE: begin
            if (slot_ok && v_rdata) begin
              v_we = 1'b1;
              k_we = stack_depth < CW'(ENTITIES);
            end
          end
          ACT_SET: begin
            if (slot_ok && prop_ok) begin
              if (v_rdata) begin
                p_we = 1'b1;
              end else begin
                v_we    = 1'b1;
                v_wdata = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      S_AVAL: begin
        v_we    = 1'b1;
        v_waddr = tgt;
        v_wdata = 1'b1;
      end
      S_ZERO: begin
        p_we    = 1'b1;
        p_waddr = {tgt, pc};
        p_wdata = '0;
      end
      S_SETW: begin
        p_we    = 1'b1;
        p_waddr = {tgt, prop_r[PW-1:0]};
      end
      S_CKV: p_raddr = {ctr, PW'(0)};
      S_CKP: ;
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      ctr         <= '0;
      clr_resp    <= 1'b0;
      stack_depth <= '0;
      fresh_next  <= '0;
      valid_count <= '0;
      frame       <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // S_DONE sets its own m_tvalid value
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          ctr <= ctr + SW'(1);
          if (ctr == LAST_SLOT) begin
            state    <= clr_resp ? S_DONE : S_IDLE;
            clr_resp <= 1'b0;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            act        <= in_action;
            slot_r     <= in_slot;
            prop_r     <= in_prop;
            wval       <= in_wval;
            res_status <= ST_DONE;
            res_slot   <= '0;
            res_rd     <= '0;
            res_sum    <= '0;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          pc    <= '0;
          case (act)
            ACT_ALLOC: begin
              if (have_stack || have_fresh) begin
                tgt       <= alloc_slot;
                res_slot  <= alloc_slot;
                set_after <= 1'b0;
                state     <= S_AVAL;
                if (have_stack) begin
                  stack_depth <= stack_depth - CW'(1);
                end else begin
                  fresh_next <= fresh_next + CW'(1);
                end
              end else begin
                res_status <= ST_NOSLOT;
              end
            end
            ACT_FREE: begin
              if (slot_ok && v_rdata) begin
                valid_count <= valid_count - CW'(1);
                if (stack_depth < CW'(ENTITIES)) begin
                  stack_depth <= stack_depth + CW'(1);
                end
              end else begin
                res_status <= ST_REJECT;
              end
            end
            ACT_GET: begin
              if (slot_ok && prop_ok && v_rdata) begin
                res_rd <= p_rdata;
              end else begin
                res_status <= ST_REJECT;
              end
            end
            ACT_SET: begin
              if (!(slot_ok && prop_ok)) begin
                res_status <= ST_REJECT;
              end else if (!v_rdata) begin
                tgt         <= slot_r[SW-1:0];
                set_after   <= 1'b1;
                valid_count <= valid_count + CW'(1);
                if (CW'(slot_r) >= fresh_next) begin
                  fresh_next <= CW'(slot_r) + CW'(1);
                end
                state <= S_ZERO;
              end
            end
            ACT_FRAME: frame <= wval;
            ACT_CLEAR: begin
              stack_depth <= '0;
              fresh_next  <= '0;
              valid_count <= '0;
              frame       <= '0;
              ctr         <= '0;
              clr_resp    <= 1'b1;
              state       <= S_CLR;
            end
            ACT_CSUM: begin
              ctr   <= '0;
              csum  <= '0;
              state <= S_CKV;
            end
            default: res_status <= ST_REJECT;
          endcase
        end
        S_AVAL: begin
          if (!v_rdata) begin
            valid_count <= valid_count + CW'(1);
          end
          state <= S_ZERO;
        end
        S_ZERO: begin
          pc <= pc + PW'(1);
          if (pc == LAST_PROP) begin
            state <= set_after ? S_SETW : S_DONE;
          end
        end
        S_SETW: state <= S_DONE;
        S_CKV: begin
          pc <= '0;
          if (v_rdata) begin
            state <= S_CKP;
          end else if (ctr == LAST_SLOT) begin
            res_sum <= csum ^ frame;
            state   <= S_DONE;
          end else begin
            ctr <= ctr + SW'(1);
          end
        end
        S_CKP: begin
          pc <= pc + PW'(1);
          if (pc != LAST_PROP) begin
            csum <= ck_rot;
          end else if (ctr == LAST_SLOT) begin
            res_sum <= ck_row ^ frame;
            state   <= S_DONE;
          end else begin
            csum  <= ck_row;
            ctr   <= ctr + SW'(1);
            state <= S_CKV;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, LIVE_W'(valid_count), res_sum, res_rd,
                         SLOT_W'(res_slot), res_status};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    valid_count <= CW'(ENTITIES)) else $error("live count above table size");
  a_stack_range: assert property (@(posedge clk) disable iff (rst)
    stack_depth <= CW'(ENTITIES)) else $error("free stack overflow");
  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("second word taken while busy");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3) else $error("bad status code");
`endif

endmodule

FILE: rtl/core/slap_ram.sv
// Simple dual-port synchronous RAM, one write and one read port.
// Read data registered. Does not use slap_pkg.
module slap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: test/tb_slot_allocator_property_table.sv
// Testbench for slot_allocator_property_table: random and directed actions,
// checked word by word against an in-bench model of the slot table.
// Depends on slap_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_slot_allocator_property_table;
  import slap_pkg::*;

  localparam int NSLOT = ENTITIES_DEF;
  localparam int NPROP = PROPERTIES_DEF;
  localparam int IDLE_LIMIT = 100000;
  localparam logic [ACTION_W-1:0] ACT_BAD = 3'd7;  // unused action code

  typedef struct packed {
    logic [VAL_W-1:0]    wval;
    logic [ID_W-1:0]     prop;
    logic [ID_W-1:0]     slot;
    logic [ACTION_W-1:0] action;
  } action_t;

  typedef struct packed {
    logic [LIVE_W-1:0]   live;
    logic [VAL_W-1:0]    csum;
    logic [VAL_W-1:0]    rd;
    logic [SLOT_W-1:0]   slot_out;
    logic [STATUS_W-1:0] status;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  slot_allocator_property_table DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial forever #6 clk = ~clk;

  // Model state of the slot table
  logic             live_bit [NSLOT];
  logic [VAL_W-1:0] rows [NSLOT][NPROP];
  logic [9:0]       free_lifo [NSLOT];
  int unsigned      lifo_depth, fresh_ptr, live_total;
  logic [VAL_W-1:0] frame_reg;

  action_t pending_actions[$];
  reply_t  expected_replies[$];
  int      errors = 0;
  int      idle_cycles = 0;
  bit      pause_sender = 0;   // sender waits for drain while set
  int      hold_rx = 0;        // long receiver stall, cycles

  // Handshakes seen at the last rising edge
  logic s_tready_q = 1'b0;
  logic m_took_q = 1'b0;

  function automatic void wipe_model();
    for (int s = 0; s < NSLOT; s++) live_bit[s] = 1'b0;
    lifo_depth = 0; fresh_ptr = 0; live_total = 0; frame_reg = '0;
  endfunction

  function automatic void open_row(int unsigned s);
    if (!live_bit[s]) begin
      live_bit[s] = 1'b1;
      live_total++;
    end
    for (int p = 0; p < NPROP; p++) rows[s][p] = '0;
  endfunction

  function automatic reply_t predict_reply(action_t a);
    reply_t r;
    bit slot_ok, prop_ok;
    logic [VAL_W-1:0] c;
    r = '0;
    slot_ok = a.slot < NSLOT;
    prop_ok = a.prop < NPROP;
    case (a.action)
      ACT_ALLOC: begin
        if (lifo_depth > 0) begin
          lifo_depth--;
          r.slot_out = free_lifo[lifo_depth];
          open_row(32'(r.slot_out));
        end else if (fresh_ptr < NSLOT) begin
          r.slot_out = fresh_ptr[9:0];
          open_row(fresh_ptr);
          fresh_ptr++;
        end else r.status = ST_NOSLOT;
      end
      ACT_FREE: begin
        if (slot_ok && live_bit[a.slot]) begin
          live_bit[a.slot] = 1'b0;
          live_total--;
          if (lifo_depth < NSLOT) begin
            free_lifo[lifo_depth] = a.slot[9:0];
            lifo_depth++;
          end
        end else r.status = ST_REJECT;
      end
      ACT_GET: begin
        if (slot_ok && prop_ok && live_bit[a.slot]) r.rd = rows[a.slot][a.prop];
        else r.status = ST_REJECT;
      end
      ACT_SET: begin
        if (slot_ok && prop_ok) begin
          if (!live_bit[a.slot]) begin
            if (32'(a.slot) >= fresh_ptr) fresh_ptr = 32'(a.slot) + 1;
            open_row(32'(a.slot));
          end
          rows[a.slot][a.prop] = a.wval;
        end else r.status = ST_REJECT;
      end
      ACT_FRAME: frame_reg = a.wval;
      ACT_CLEAR: wipe_model();
      ACT_CSUM: begin
        c = '0;
        for (int s = 0; s < NSLOT; s++) begin
          if (live_bit[s]) begin
            for (int p = 0; p < NPROP; p++) begin
              c = c ^ rows[s][p];
              c = {c[30:0], c[31]};
            end
            c = c ^ VAL_W'(s);
          end
        end
        r.csum = c ^ frame_reg;
      end
      default: r.status = ST_REJECT;
    endcase
    r.live = live_total[LIVE_W-1:0];
    return r;
  endfunction

  function automatic action_t mk(logic [2:0] op, int unsigned s, int unsigned p,
                                 logic [31:0] v);
    action_t a;
    a.action = op; a.slot = s[15:0]; a.prop = p[15:0]; a.wval = v;
    return a;
  endfunction

  // Mostly in-range slots/props; a share of arbitrary 16-bit values
  function automatic action_t rand_action(int unsigned hot);
    action_t a;
    int unsigned k;
    k = $urandom_range(99);
    if (k < 22) a.action = ACT_ALLOC;
    else if (k < 40) a.action = ACT_FREE;
    else if (k < 62) a.action = ACT_GET;
    else if (k < 88) a.action = ACT_SET;
    else if (k < 93) a.action = ACT_FRAME;
    else if (k < 96) a.action = ACT_CSUM;
    else if (k < 98) a.action = ACT_BAD;
    else a.action = ACT_CLEAR;
    a.slot = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(hot));
    a.prop = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(NPROP - 1));
    a.wval = $urandom;
    return a;
  endfunction

  // Driver: one word per entry of pending_actions, random gap before each
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready_q) begin
        s_tvalid <= 1'b0;
        gap_left <= $urandom_range(11);
      end else if (!s_tvalid) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (pending_actions.size() > 0 &&
                 !(pause_sender && expected_replies.size() > 0)) begin
          s_tdata <= IN_W'(pending_actions.pop_front());
          s_tvalid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    s_tready_q <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready)
      expected_replies.push_back(predict_reply(action_t'(s_tdata[66:0])));
  end

  // Receiver: random stall per word, plus one long hold
  int stall_left = 0;
  always @(negedge clk) begin
    int draw;
    if (!rst) begin
      if (hold_rx > 0) begin
        m_tready <= 1'b0;
        hold_rx <= hold_rx - 1;
      end else if (m_tready && m_took_q) begin
        draw = $urandom_range(11);
        if ($urandom_range(3) == 0) draw = 0;
        m_tready <= (draw == 0);
        stall_left <= draw;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready <= (stall_left == 1);
      end else m_tready <= 1'b1;
    end
  end

  // Monitor
  always @(posedge clk) begin
    reply_t got, want;
    m_took_q <= m_tvalid && m_tready;
    if (!rst && m_tvalid && m_tready) begin
      got = reply_t'(m_tdata[86:0]);
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, got);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (got.status !== want.status || got.slot_out !== want.slot_out ||
            got.rd !== want.rd || got.csum !== want.csum || got.live !== want.live) begin
          $display("%0t: mismatch expected st=%0d slot=%0d rd=%h sum=%h live=%0d",
                   $realtime, want.status, want.slot_out, want.rd, want.csum, want.live);
          $display("%0t:          actual st=%0d slot=%0d rd=%h sum=%h live=%0d",
                   $realtime, got.status, got.slot_out, got.rd, got.csum, got.live);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned hot;
    wipe_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes and each special case
    pending_actions.push_back(mk(ACT_GET, 0, 0, 0));                  // invalid slot
    pending_actions.push_back(mk(ACT_FREE, 3, 0, 0));                 // free invalid
    pending_actions.push_back(mk(ACT_ALLOC, 0, 0, 0));
    pending_actions.push_back(mk(ACT_ALLOC, 0, 0, 0));
    pending_actions.push_back(mk(ACT_SET, 1, NPROP - 1, 32'h8000_0000));
    pending_actions.push_back(mk(ACT_SET, 0, 0, 32'h7fff_ffff));
    pending_actions.push_back(mk(ACT_GET, 1, NPROP - 1, 0));
    pending_actions.push_back(mk(ACT_GET, 1, NPROP, 0));              // prop out of range
    pending_actions.push_back(mk(ACT_SET, 16'hffff, 0, 1));           // slot out of range
    pending_actions.push_back(mk(ACT_SET, 5, 16'hffff, 1));
    pending_actions.push_back(mk(ACT_SET, NSLOT - 1, 3, 32'hffff_ffff)); // moves fresh
    pending_actions.push_back(mk(ACT_FREE, 0, 0, 0));
    pending_actions.push_back(mk(ACT_SET, 0, 2, 32'h1234_5678));      // stale stack entry
    pending_actions.push_back(mk(ACT_ALLOC, 0, 0, 0));                // hands 0 again
    pending_actions.push_back(mk(ACT_FREE, 16'hffff, 0, 0));
    pending_actions.push_back(mk(ACT_FRAME, 0, 0, 32'hdead_beef));
    pending_actions.push_back(mk(ACT_CSUM, 0, 0, 0));
    pending_actions.push_back(mk(ACT_BAD, 16'hffff, 16'hffff, 32'hffff_ffff));
    pending_actions.push_back(mk(ACT_ALLOC, 0, 0, 0));                // no slot left
    pending_actions.push_back(mk(ACT_CLEAR, 0, 0, 0));
    pending_actions.push_back(mk(ACT_CSUM, 0, 0, 0));
    wait (pending_actions.size() == 0);

    // Long receiver hold while the sender keeps offering
    hold_rx = 300;
    for (int i = 0; i < 20; i++) pending_actions.push_back(rand_action(15));
    wait (pending_actions.size() == 0);

    // Sender pause until everything drained
    pause_sender = 1;
    for (int i = 0; i < 5; i++) pending_actions.push_back(rand_action(15));
    wait (pending_actions.size() == 0 && expected_replies.size() == 0);
    pause_sender = 0;

    // Random: small working sets mostly, sometimes the full range
    for (int i = 0; i < 600; i++) begin
      hot = (i % 400 < 300) ? 31 : NSLOT - 1;
      pending_actions.push_back(rand_action(hot));
      if (pending_actions.size() > 16) wait (pending_actions.size() < 8);
    end
    // Fill the table so allocate can run dry
    for (int i = 0; i < NSLOT + 2; i++) pending_actions.push_back(mk(ACT_ALLOC, 0, 0, 0));
    pending_actions.push_back(mk(ACT_FREE, 7, 0, 0));
    pending_actions.push_back(mk(ACT_CSUM, 0, 0, 0));
    wait (pending_actions.size() == 0 && !s_tvalid && expected_replies.size() == 0);
    repeat (2 * NSLOT) @(posedge clk);
    if (errors == 0 && expected_replies.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/slap_pkg.sv
rtl/core/slap_ram.sv
rtl/core/slot_allocator_property_table.sv
test/tb_slot_allocator_property_table.sv
